@@ rtl/gpdl_pkg.sv @@
// Shared types and constants for the gate PWM duty limiter.
`default_nettype none

package gpdl_pkg;

   // Fraction bits of the internal duty value
   localparam int DUTY_FRAC_BITS_DEF = 16;

   // Port and register widths
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int SAMPLE_W    = 24;
   localparam int MAG_W       = 23;
   localparam int PERIOD_W    = 16;
   localparam int LOAD_W      = 24;
   localparam int DUTY_Q16_W  = 17;
   localparam int MODE_W      = 2;

   // Product of setpoint and load resistance; bank voltage times 1000
   localparam int NUM_W       = MAG_W + LOAD_W;
   localparam int DEN_W       = MAG_W + 10;
   localparam int MV_PER_V    = 1000;

   // Register reset values
   localparam logic [PERIOD_W-1:0]   PERIOD_RST   = 16'hFFFF;
   localparam logic [MAG_W-1:0]      OVER_V_RST   = 23'h7FFFFF;
   localparam logic [LOAD_W-1:0]     MIN_LOAD_RST = 24'd1000;
   localparam logic [MAG_W-1:0]      I_LIMIT_RST  = 23'h7FFFFF;
   localparam logic [DUTY_Q16_W-1:0] MIN_DUTY_RST = 17'd0;
   localparam logic [DUTY_Q16_W-1:0] MAX_DUTY_RST = 17'h10000;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PWM_ENABLED  = 3'd0,
      CSR_PERIOD_TOP   = 3'd1,
      CSR_OVER_VOLTAGE = 3'd2,
      CSR_MIN_LOAD     = 3'd3,
      CSR_CURRENT_LIM  = 3'd4,
      CSR_MIN_DUTY     = 3'd5,
      CSR_MAX_DUTY     = 3'd6
   } csr_index_type;

   // Drive mode codes as published
   typedef enum logic [MODE_W-1:0] {
      MODE_OFF    = 2'd0,
      MODE_FULL   = 2'd1,
      MODE_NORMAL = 2'd2,
      MODE_HOLD   = 2'd3
   } mode_type;

   // Side information that travels with each transaction
   typedef struct packed {
      mode_type mode;       // NORMAL while the duty is still being worked out
      logic     fault;
      logic     meas_over;  // measured current above clamped setpoint
   } ctl_type;

endpackage

`default_nettype wire

@@ rtl/gate_pwm_duty_limiter.sv @@
// Top level of the gate PWM duty limiter: pipelined duty computation.
//
//  Channel | Ports                                           | Handshake
//  --------+-------------------------------------------------+------------------------
//  request | start, busy, req_* (six sample fields)          | taken when start & !busy
//  result  | rsp_strobe, rsp_compare_value, rsp_drive_mode,  | one cycle, no back-pressure
//          | rsp_fault_flag                                  |
//  config  | csr_we, csr_index, csr_wdata                    | written when csr_we
//
// One transaction per clock. Each result is registered through stage 1, stage 2,
// the saturation test, the restoring divider with one quotient bit per stage,
// stage A, stage B and the output stage, in that order.
// Synchronous reset empties the pipeline and loads register defaults; busy is high
// only during reset. The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module gate_pwm_duty_limiter #(
   parameter int DUTY_FRAC_BITS = gpdl_pkg::DUTY_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request
   input  wire logic                              start,
   output      logic                              busy,
   input  wire logic                              req_gate_fault,
   input  wire logic                              req_output_enabled,
   input  wire logic                              req_wave_running,
   input  wire logic signed [gpdl_pkg::SAMPLE_W-1:0] req_set_current_ma,
   input  wire logic signed [gpdl_pkg::SAMPLE_W-1:0] req_bank_voltage_mv,
   input  wire logic signed [gpdl_pkg::SAMPLE_W-1:0] req_measured_current_ma,
   // result
   output      logic                              rsp_strobe,
   output      logic [gpdl_pkg::PERIOD_W-1:0]     rsp_compare_value,
   output      logic [gpdl_pkg::MODE_W-1:0]       rsp_drive_mode,
   output      logic                              rsp_fault_flag,
   // configuration
   input  wire logic                              csr_we,
   input  wire logic [gpdl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [gpdl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int F       = DUTY_FRAC_BITS;
   localparam int DUTY_W  = F + 1;
   localparam int CMP_W   = F + 17;
   localparam int DB_W    = DUTY_W + 5;
   localparam int PROD_W  = DUTY_W + gpdl_pkg::PERIOD_W + 1;
   localparam int RAW_W   = gpdl_pkg::PERIOD_W + 1;
   localparam int LATENCY = F + 6;
   localparam int DEN_W   = gpdl_pkg::DEN_W;
   localparam int NUM_W   = gpdl_pkg::NUM_W;
   localparam int MAG_W   = gpdl_pkg::MAG_W;

   localparam logic [DUTY_W-1:0] ONE      = DUTY_W'(1) << F;
   localparam logic [DB_W-1:0]   DB_LOW   = DB_W'(ONE);
   localparam logic [DB_W-1:0]   DB_HIGH  = DB_W'(19) * DB_W'(ONE);
   localparam logic [PROD_W-1:0] HALF     = PROD_W'(1) << (F - 1);

   // ---------------------------------------------------------------------------
   // Configuration registers
   logic                                pwm_enabled_ff;
   logic [gpdl_pkg::PERIOD_W-1:0]       period_top_ff;
   logic [MAG_W-1:0]                    over_voltage_ff;
   logic [gpdl_pkg::LOAD_W-1:0]         min_load_ff;
   logic [MAG_W-1:0]                    current_limit_ff;
   logic [gpdl_pkg::DUTY_Q16_W-1:0]     min_duty_ff;
   logic [gpdl_pkg::DUTY_Q16_W-1:0]     max_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_enabled_ff   <= 1'b0;
         period_top_ff    <= gpdl_pkg::PERIOD_RST;
         over_voltage_ff  <= gpdl_pkg::OVER_V_RST;
         min_load_ff      <= gpdl_pkg::MIN_LOAD_RST;
         current_limit_ff <= gpdl_pkg::I_LIMIT_RST;
         min_duty_ff      <= gpdl_pkg::MIN_DUTY_RST;
         max_duty_ff      <= gpdl_pkg::MAX_DUTY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            gpdl_pkg::CSR_PWM_ENABLED:  pwm_enabled_ff   <= csr_wdata[0];
            gpdl_pkg::CSR_PERIOD_TOP:   period_top_ff    <= csr_wdata[gpdl_pkg::PERIOD_W-1:0];
            gpdl_pkg::CSR_OVER_VOLTAGE: over_voltage_ff  <= csr_wdata[MAG_W-1:0];
            gpdl_pkg::CSR_MIN_LOAD:     min_load_ff      <= csr_wdata[gpdl_pkg::LOAD_W-1:0];
            gpdl_pkg::CSR_CURRENT_LIM:  current_limit_ff <= csr_wdata[MAG_W-1:0];
            gpdl_pkg::CSR_MIN_DUTY:     min_duty_ff      <= csr_wdata[gpdl_pkg::DUTY_Q16_W-1:0];
            gpdl_pkg::CSR_MAX_DUTY:     max_duty_ff      <= csr_wdata[gpdl_pkg::DUTY_Q16_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // ---------------------------------------------------------------------------
   // Stage 1: early exits, setpoint clamp, headroom
   logic                 s1_vld_ff;
   gpdl_pkg::ctl_type    s1_ctl_ff, s1_ctl_in;
   logic [MAG_W-1:0]     s1_iset_ff, s1_iset_in;
   logic [MAG_W-1:0]     s1_volt_ff;

   always_comb begin
      logic [MAG_W-1:0] set_pos;
      logic             volt_pos;
      set_pos  = (!req_set_current_ma[gpdl_pkg::SAMPLE_W-1] && req_set_current_ma != '0)
               ? req_set_current_ma[MAG_W-1:0] : '0;
      volt_pos = !req_bank_voltage_mv[gpdl_pkg::SAMPLE_W-1] && req_bank_voltage_mv != '0;
      s1_iset_in = (set_pos > current_limit_ff) ? current_limit_ff : set_pos;

      s1_ctl_in.fault     = req_gate_fault;
      s1_ctl_in.meas_over = req_measured_current_ma > $signed({1'b0, s1_iset_in});
      priority if (!pwm_enabled_ff) begin
         s1_ctl_in.mode  = gpdl_pkg::MODE_HOLD;
         s1_ctl_in.fault = 1'b0;
      end else if (req_gate_fault || !req_output_enabled
                   || req_bank_voltage_mv >= $signed({1'b0, over_voltage_ff})) begin
         s1_ctl_in.mode = gpdl_pkg::MODE_OFF;
      end else if (!req_wave_running && set_pos == '0) begin
         s1_ctl_in.mode = gpdl_pkg::MODE_OFF;
      end else if (!volt_pos) begin
         s1_ctl_in.mode = gpdl_pkg::MODE_OFF;
      end else begin
         s1_ctl_in.mode = gpdl_pkg::MODE_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= accept;
      s1_ctl_ff  <= s1_ctl_in;
      s1_iset_ff <= s1_iset_in;
      s1_volt_ff <= req_bank_voltage_mv[MAG_W-1:0];
   end

   // ---------------------------------------------------------------------------
   // Stage 2: numerator Iset*R and denominator 1000*V
   // A zero load register stands for a huge guard resistance: any nonzero
   // clamped setpoint then saturates the duty, a zero one gives zero.
   logic                 s2_vld_ff;
   gpdl_pkg::ctl_type    s2_ctl_ff;
   logic [NUM_W-1:0]     s2_num_ff;
   logic [DEN_W-1:0]     s2_den_ff;
   logic                 s2_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else       s2_vld_ff <= s1_vld_ff;
      s2_ctl_ff <= s1_ctl_ff;
      s2_num_ff <= NUM_W'(s1_iset_ff) * NUM_W'(min_load_ff);
      s2_den_ff <= DEN_W'(s1_volt_ff) * DEN_W'(gpdl_pkg::MV_PER_V);
      s2_sat_ff <= (min_load_ff == '0) && (s1_iset_ff != '0);
   end

   // ---------------------------------------------------------------------------
   // Stage 3 and divider: saturation test, then one quotient bit per stage
   logic                   dv_vld_ff  [0:F];
   gpdl_pkg::ctl_type      dv_ctl_ff  [0:F];
   logic                   dv_full_ff [0:F];
   logic [DEN_W-1:0]       dv_den_ff  [0:F];
   logic [DEN_W-1:0]       dv_rem_ff  [0:F];
   logic [F-1:0]           dv_quo_ff  [0:F];

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else       dv_vld_ff[0] <= s2_vld_ff;
      dv_ctl_ff[0]  <= s2_ctl_ff;
      dv_full_ff[0] <= s2_sat_ff || (s2_num_ff >= NUM_W'(s2_den_ff));
      dv_den_ff[0]  <= s2_den_ff;
      dv_rem_ff[0]  <= s2_num_ff[DEN_W-1:0];
      dv_quo_ff[0]  <= '0;
   end

   for (genvar k = 1; k <= F; k++) begin : g_div
      logic [DEN_W:0]   two_in;
      logic             ge_in;
      logic [DEN_W-1:0] rem_in;
      logic [DEN_W:0]   diff_in;

      // restoring step: double the remainder, subtract the divisor if it fits
      assign two_in  = {dv_rem_ff[k-1], 1'b0};
      assign ge_in   = two_in >= {1'b0, dv_den_ff[k-1]};
      assign diff_in = two_in - {1'b0, dv_den_ff[k-1]};
      assign rem_in  = ge_in ? diff_in[DEN_W-1:0] : two_in[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[k] <= 1'b0;
         else       dv_vld_ff[k] <= dv_vld_ff[k-1];
         dv_ctl_ff[k]  <= dv_ctl_ff[k-1];
         dv_full_ff[k] <= dv_full_ff[k-1];
         dv_den_ff[k]  <= dv_den_ff[k-1];
         dv_rem_ff[k]  <= rem_in;
         dv_quo_ff[k]  <= {dv_quo_ff[k-1][F-2:0], ge_in};
      end
   end

   // ---------------------------------------------------------------------------
   // Stage A: duty limits and deadbands
   logic                 sa_vld_ff;
   logic                 sa_fault_ff;
   gpdl_pkg::mode_type   sa_mode_ff, sa_mode_in;
   logic [DUTY_W-1:0]    sa_duty_ff, sa_duty_in;

   always_comb begin
      logic [DUTY_W-1:0] duty;
      logic [CMP_W-1:0]  duty_cmp;
      logic [CMP_W-1:0]  min_cmp;
      logic [CMP_W-1:0]  max_cmp;
      logic [DB_W-1:0]   duty_x20;
      duty = dv_full_ff[F] ? ONE : {1'b0, dv_quo_ff[F]};
      if (dv_ctl_ff[F].meas_over) duty = '0;
      duty_cmp = CMP_W'(duty) << 16;
      min_cmp  = CMP_W'(min_duty_ff) << F;
      max_cmp  = CMP_W'(max_duty_ff) << F;
      duty_x20 = DB_W'(duty) * DB_W'(20);

      sa_duty_in = duty;
      sa_mode_in = dv_ctl_ff[F].mode;
      if (dv_ctl_ff[F].mode == gpdl_pkg::MODE_NORMAL) begin
         priority if (duty_cmp < min_cmp) begin
            sa_mode_in = gpdl_pkg::MODE_OFF;
         end else if (duty_cmp > max_cmp) begin
            sa_mode_in = gpdl_pkg::MODE_FULL;
         end else if (duty_x20 <= DB_LOW) begin
            sa_duty_in = '0;
         end else if (duty_x20 >= DB_HIGH) begin
            sa_duty_in = ONE;
         end else begin
            sa_duty_in = duty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) sa_vld_ff <= 1'b0;
      else       sa_vld_ff <= dv_vld_ff[F];
      sa_fault_ff <= dv_ctl_ff[F].fault;
      sa_mode_ff  <= sa_mode_in;
      sa_duty_ff  <= sa_duty_in;
   end

   // ---------------------------------------------------------------------------
   // Stage B: scale to the period with rounding
   logic                 sb_vld_ff;
   logic                 sb_fault_ff;
   gpdl_pkg::mode_type   sb_mode_ff;
   logic [RAW_W-1:0]     sb_raw_ff;
   logic [PROD_W-1:0]    sb_prod_in;

   assign sb_prod_in = PROD_W'(sa_duty_ff) * PROD_W'({1'b0, period_top_ff} + RAW_W'(1))
                     + HALF;

   always_ff @(posedge clock) begin
      if (reset) sb_vld_ff <= 1'b0;
      else       sb_vld_ff <= sa_vld_ff;
      sb_fault_ff <= sa_fault_ff;
      sb_mode_ff  <= sa_mode_ff;
      sb_raw_ff   <= sb_prod_in[F +: RAW_W];
   end

   // ---------------------------------------------------------------------------
   // Output stage: cap at the period, pick the compare by mode
   logic                           rsp_strobe_ff;
   logic [gpdl_pkg::PERIOD_W-1:0]  rsp_compare_ff, rsp_compare_in;
   gpdl_pkg::mode_type             rsp_mode_ff;
   logic                           rsp_fault_ff;

   always_comb begin
      unique case (sb_mode_ff)
         gpdl_pkg::MODE_NORMAL:
            rsp_compare_in = (sb_raw_ff > RAW_W'(period_top_ff))
                           ? period_top_ff : sb_raw_ff[gpdl_pkg::PERIOD_W-1:0];
         gpdl_pkg::MODE_FULL: rsp_compare_in = period_top_ff;
         default:             rsp_compare_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= sb_vld_ff;
      rsp_compare_ff <= rsp_compare_in;
      rsp_mode_ff    <= sb_mode_ff;
      rsp_fault_ff   <= sb_fault_ff;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_compare_value = rsp_compare_ff;
   assign rsp_drive_mode    = rsp_mode_ff;
   assign rsp_fault_flag    = rsp_fault_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a request at the pipeline depth");

   a_hold_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_drive_mode == gpdl_pkg::MODE_HOLD
         |-> rsp_compare_value == '0 && !rsp_fault_flag)
      else $error("no-update result carries data");

   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_drive_mode == gpdl_pkg::MODE_OFF |-> rsp_compare_value == '0)
      else $error("off result with nonzero compare");

   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_drive_mode == gpdl_pkg::MODE_NORMAL
                     || rsp_drive_mode == gpdl_pkg::MODE_FULL)
         |-> rsp_compare_value <= period_top_ff)
      else $error("compare above period");

endmodule

`default_nettype wire

@@ tb/sv/tb_gate_pwm_duty_limiter.sv @@
// Self-checking testbench for the gate PWM duty limiter: directed table plus random traffic.
`timescale 1ns / 100ps

module tb_gate_pwm_duty_limiter;
   import gpdl_pkg::*;

   localparam int FRAC = DUTY_FRAC_BITS_DEF;
   // request edge to result edge
   localparam int PIPE_LAT = FRAC + 6;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 130;
   localparam bit [63:0] GUARD_MILLIOHM = 64'd1000000000000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   // One request: gate flags plus the three signed samples
   typedef struct {
      logic                       fault;
      logic                       enabled;
      logic                       wave;
      logic signed [SAMPLE_W-1:0] set_ma;
      logic signed [SAMPLE_W-1:0] volt_mv;
      logic signed [SAMPLE_W-1:0] meas_ma;
   } sample_t;

   // One gate update as published
   typedef struct {
      logic [PERIOD_W-1:0] cmp;
      mode_type            mode;
      logic                fault;
   } gate_drive_t;

   // Directed script row: a register write or a transaction
   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      sample_t                smp;
      bit                     typed;
      gate_drive_t            want;
   } step_t;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_gate_fault;
   logic                       req_output_enabled;
   logic                       req_wave_running;
   logic signed [SAMPLE_W-1:0] req_set_current_ma;
   logic signed [SAMPLE_W-1:0] req_bank_voltage_mv;
   logic signed [SAMPLE_W-1:0] req_measured_current_ma;
   logic                       rsp_strobe;
   logic [PERIOD_W-1:0]        rsp_compare_value;
   logic [MODE_W-1:0]          rsp_drive_mode;
   logic                       rsp_fault_flag;
   logic                       csr_we;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   // Register mirror
   logic                  cfg_pwm_en;
   logic [PERIOD_W-1:0]   cfg_period_top;
   logic [MAG_W-1:0]      cfg_over_v;
   logic [LOAD_W-1:0]     cfg_min_load;
   logic [MAG_W-1:0]      cfg_i_limit;
   logic [DUTY_Q16_W-1:0] cfg_min_duty;
   logic [DUTY_Q16_W-1:0] cfg_max_duty;

   gate_drive_t pending_drive[$];
   step_t       script[$];
   int          n_fail;
   int          n_sent;
   int          n_checked;
   int          n_settings;
   int          quiet;
   int          mode_hits[4];

   gate_pwm_duty_limiter dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_gate_fault         (req_gate_fault),
      .req_output_enabled     (req_output_enabled),
      .req_wave_running       (req_wave_running),
      .req_set_current_ma     (req_set_current_ma),
      .req_bank_voltage_mv    (req_bank_voltage_mv),
      .req_measured_current_ma(req_measured_current_ma),
      .rsp_strobe             (rsp_strobe),
      .rsp_compare_value      (rsp_compare_value),
      .rsp_drive_mode         (rsp_drive_mode),
      .rsp_fault_flag         (rsp_fault_flag),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Expected gate update for one sample under the current register mirror
   function automatic gate_drive_t calc_gate_drive(sample_t s);
      gate_drive_t d;
      longint      set_s, volt_s, meas_s;
      bit [63:0]   one, iset, v, r, num, den, duty, ccr;
      one = 64'd1 << FRAC;
      set_s = s.set_ma;
      volt_s = s.volt_mv;
      meas_s = s.meas_ma;
      d.cmp = '0;
      d.mode = MODE_OFF;
      d.fault = s.fault;
      if (!cfg_pwm_en) begin
         d.mode = MODE_HOLD;
         d.fault = 1'b0;
         return d;
      end
      // fault, disable, over-voltage, idle, no headroom
      if (s.fault || !s.enabled || volt_s >= longint'(cfg_over_v)) return d;
      if (!s.wave && set_s <= 0) return d;
      if (volt_s <= 0) return d;
      v = volt_s;
      iset = (set_s > 0) ? set_s : 64'sd0;
      if (iset > 64'(cfg_i_limit)) iset = 64'(cfg_i_limit);
      r = (cfg_min_load != 0) ? 64'(cfg_min_load) : GUARD_MILLIOHM;
      num = iset * r;
      den = 64'(MV_PER_V) * v;
      duty = (num >= den) ? one : (num << FRAC) / den;
      if (meas_s > longint'(iset)) duty = '0;
      // min/max duty limits on the quantized duty
      if ((duty << 16) < (64'(cfg_min_duty) << FRAC)) return d;
      if ((duty << 16) > (64'(cfg_max_duty) << FRAC)) begin
         d.mode = MODE_FULL;
         d.cmp = cfg_period_top;
         return d;
      end
      // 5% / 95% deadbands
      if (duty * 20 <= one) duty = '0;
      else if (duty * 20 >= 19 * one) duty = one;
      if (duty == 0) begin
         ccr = '0;
      end else begin
         ccr = (duty * (64'(cfg_period_top) + 1) + (one >> 1)) >> FRAC;
         if (ccr > 64'(cfg_period_top)) ccr = 64'(cfg_period_top);
      end
      d.mode = MODE_NORMAL;
      d.cmp = ccr[PERIOD_W-1:0];
      return d;
   endfunction

   // Random sample: mostly well-formed drive requests, some raw noise
   function automatic sample_t make_sample();
      sample_t     s;
      int unsigned vmax, v, duty_tgt, pick;
      bit [63:0]   r, set_u;
      if ($urandom_range(0, 99) < 15) begin
         s.fault = 1'($urandom);
         s.enabled = 1'($urandom);
         s.wave = 1'($urandom);
         s.set_ma = SAMPLE_W'($urandom);
         s.volt_mv = SAMPLE_W'($urandom);
         s.meas_ma = SAMPLE_W'($urandom);
         return s;
      end
      s.fault = ($urandom_range(0, 19) == 0);
      s.enabled = ($urandom_range(0, 19) != 0);
      s.wave = ($urandom_range(0, 7) != 0);
      vmax = (cfg_over_v > 1) ? 32'(cfg_over_v) - 1 : 1;
      if ($urandom_range(0, 1) == 1 && vmax > 30000) vmax = 30000;
      v = $urandom_range(1, vmax);
      s.volt_mv = SAMPLE_W'(v);
      // aim the setpoint at a chosen duty so the whole range gets visited
      r = (cfg_min_load != 0) ? 64'(cfg_min_load) : GUARD_MILLIOHM;
      duty_tgt = $urandom_range(0, 72000);
      set_u = (64'(duty_tgt) * 64'(MV_PER_V) * 64'(v)) / (r * 64'd65536);
      if (set_u > 64'd8388607) set_u = 64'd8388607;
      if ($urandom_range(0, 7) == 0) set_u = 64'($urandom_range(0, 8388607));
      s.set_ma = set_u[SAMPLE_W-1:0];
      if ($urandom_range(0, 15) == 0)
         s.set_ma = SAMPLE_W'(-$signed({1'b0, $urandom_range(0, 5000)}));
      pick = $urandom_range(0, 99);
      if (pick < 85) s.meas_ma = SAMPLE_W'(s.set_ma - $urandom_range(0, 2000));
      else if (pick < 95) s.meas_ma = SAMPLE_W'(s.set_ma + $urandom_range(1, 100));
      else s.meas_ma = SAMPLE_W'($urandom);
      return s;
   endfunction

   function automatic void csr_row(logic [CSR_INDEX_W-1:0] idx, int val);
      step_t st;
      st.is_csr = 1'b1;
      st.csr_idx = idx;
      st.csr_val = CSR_DATA_W'(val);
      st.typed = 1'b0;
      script.push_back(st);
   endfunction

   function automatic void sample_row(int f, int e, int w, int set_ma, int volt_mv,
                                      int meas_ma, int typed, int cmp, mode_type mode,
                                      int flt);
      step_t st;
      st.is_csr = 1'b0;
      st.csr_idx = '0;
      st.csr_val = '0;
      st.smp.fault = (f != 0);
      st.smp.enabled = (e != 0);
      st.smp.wave = (w != 0);
      st.smp.set_ma = SAMPLE_W'(set_ma);
      st.smp.volt_mv = SAMPLE_W'(volt_mv);
      st.smp.meas_ma = SAMPLE_W'(meas_ma);
      st.typed = (typed != 0);
      st.want.cmp = PERIOD_W'(cmp);
      st.want.mode = mode;
      st.want.fault = (flt != 0);
      script.push_back(st);
   endfunction

   // Register write, one cycle of write enable
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_PWM_ENABLED:  cfg_pwm_en = val[0];
         CSR_PERIOD_TOP:   cfg_period_top = val[PERIOD_W-1:0];
         CSR_OVER_VOLTAGE: cfg_over_v = val[MAG_W-1:0];
         CSR_MIN_LOAD:     cfg_min_load = val[LOAD_W-1:0];
         CSR_CURRENT_LIM:  cfg_i_limit = val[MAG_W-1:0];
         CSR_MIN_DUTY:     cfg_min_duty = val[DUTY_Q16_W-1:0];
         CSR_MAX_DUTY:     cfg_max_duty = val[DUTY_Q16_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Present one transaction and hold it until taken
   task automatic send_sample(sample_t s, bit typed, gate_drive_t want);
      @(negedge clock);
      start <= 1'b1;
      req_gate_fault <= s.fault;
      req_output_enabled <= s.enabled;
      req_wave_running <= s.wave;
      req_set_current_ma <= s.set_ma;
      req_bank_voltage_mv <= s.volt_mv;
      req_measured_current_ma <= s.meas_ma;
      do @(posedge clock); while (busy !== 1'b0);
      pending_drive.push_back(typed ? want : calc_gate_drive(s));
      n_sent++;
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Stop sending and let the pipeline run dry before touching registers
   task automatic drain();
      idle_cycles(1);
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (PIPE_LAT) @(posedge clock);
      n_settings++;
   endtask

   task automatic random_config(int phase);
      int unsigned sel;
      write_csr(CSR_PWM_ENABLED, CSR_DATA_W'((phase == 1) ? 0 : 1));
      if (phase == 0) begin
         // all limits wide open, smallest non-guard load
         write_csr(CSR_PERIOD_TOP, CSR_DATA_W'(65535));
         write_csr(CSR_OVER_VOLTAGE, CSR_DATA_W'(8388607));
         write_csr(CSR_MIN_LOAD, CSR_DATA_W'(1));
         write_csr(CSR_CURRENT_LIM, CSR_DATA_W'(8388607));
         write_csr(CSR_MIN_DUTY, CSR_DATA_W'(0));
         write_csr(CSR_MAX_DUTY, CSR_DATA_W'(65536));
         return;
      end
      sel = $urandom_range(0, 3);
      write_csr(CSR_PERIOD_TOP, CSR_DATA_W'((sel == 0) ? 0 : (sel == 1) ? 1 :
                (sel == 2) ? 65535 : $urandom_range(2, 65534)));
      sel = $urandom_range(0, 9);
      write_csr(CSR_OVER_VOLTAGE, CSR_DATA_W'((sel == 0) ? 0 : (sel == 1) ? 8388607 :
                (sel < 6) ? $urandom_range(1000, 60000) : $urandom_range(1, 8388607)));
      sel = $urandom_range(0, 5);
      write_csr(CSR_MIN_LOAD, CSR_DATA_W'((sel == 0) ? 0 : (sel == 1) ? 1 :
                (sel == 2) ? 16777215 : $urandom_range(100, 200000)));
      sel = $urandom_range(0, 5);
      write_csr(CSR_CURRENT_LIM, CSR_DATA_W'((sel == 0) ? 0 : (sel == 1) ? 8388607 :
                $urandom_range(1, 60000)));
      sel = $urandom_range(0, 5);
      write_csr(CSR_MIN_DUTY, CSR_DATA_W'((sel < 3) ? 0 : (sel == 3) ? 65536 :
                $urandom_range(0, 20000)));
      sel = $urandom_range(0, 5);
      write_csr(CSR_MAX_DUTY, CSR_DATA_W'((sel < 3) ? 65536 : (sel == 3) ? 0 :
                $urandom_range(40000, 65536)));
   endtask

   // Result checker: each strobe is matched against the oldest expectation
   always @(posedge clock) begin
      gate_drive_t want;
      if (!reset && rsp_strobe) begin
         if (pending_drive.size() == 0) begin
            $error("result with no transaction pending");
            n_fail++;
         end else begin
            want = pending_drive.pop_front();
            n_checked++;
            mode_hits[want.mode]++;
            if (rsp_compare_value !== want.cmp) begin
               $error("compare_value: expected %0d, got %0d", want.cmp, rsp_compare_value);
               n_fail++;
            end
            if (rsp_drive_mode !== want.mode) begin
               $error("drive_mode: expected %0d, got %0d", want.mode, rsp_drive_mode);
               n_fail++;
            end
            if (rsp_fault_flag !== want.fault) begin
               $error("fault_flag: expected %0d, got %0d", want.fault, rsp_fault_flag);
               n_fail++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $error("no progress for %0d cycles", quiet);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int          ph, n, gap_sel, n_directed;
      bit          burst;
      gate_drive_t none;
      none = '{cmp: '0, mode: MODE_OFF, fault: 1'b0};
      n_fail = 0;
      n_sent = 0;
      n_checked = 0;
      n_settings = 0;
      quiet = 0;
      mode_hits = '{default: 0};
      reset = 1'b1;
      start = 1'b0;
      req_gate_fault = 1'b0;
      req_output_enabled = 1'b0;
      req_wave_running = 1'b0;
      req_set_current_ma = '0;
      req_bank_voltage_mv = '0;
      req_measured_current_ma = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_pwm_en = 1'b0;
      cfg_period_top = PERIOD_RST;
      cfg_over_v = OVER_V_RST;
      cfg_min_load = MIN_LOAD_RST;
      cfg_i_limit = I_LIMIT_RST;
      cfg_min_duty = MIN_DUTY_RST;
      cfg_max_duty = MAX_DUTY_RST;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Timer stopped after reset: no update, fault not published
      sample_row(0, 1, 1, 5000, 12000, 0, 1, 0, MODE_HOLD, 0);
      sample_row(1, 1, 1, 5000, 12000, 0, 1, 0, MODE_HOLD, 0);
      // Small period, moderate limits
      csr_row(CSR_PWM_ENABLED, 1);
      csr_row(CSR_PERIOD_TOP, 999);
      csr_row(CSR_OVER_VOLTAGE, 24000);
      csr_row(CSR_MIN_LOAD, 1000);
      csr_row(CSR_CURRENT_LIM, 10000);
      csr_row(CSR_MIN_DUTY, 0);
      csr_row(CSR_MAX_DUTY, 65536);
      sample_row(1, 1, 1, 5000, 12000, 0, 1, 0, MODE_OFF, 1);            // gate fault
      sample_row(0, 0, 1, 5000, 12000, 0, 1, 0, MODE_OFF, 0);            // output disabled
      sample_row(0, 1, 1, 5000, 24000, 0, 1, 0, MODE_OFF, 0);            // at over-voltage
      sample_row(0, 1, 1, 5000, 23999, 0, 0, 0, MODE_OFF, 0);
      sample_row(0, 1, 0, 0, 12000, 0, 1, 0, MODE_OFF, 0);               // idle
      sample_row(0, 1, 0, -8388608, 12000, 0, 1, 0, MODE_OFF, 0);
      sample_row(0, 1, 0, 100, 12000, 0, 0, 0, MODE_OFF, 0);
      sample_row(0, 1, 1, 5000, 0, 0, 1, 0, MODE_OFF, 0);                // no headroom
      sample_row(0, 1, 1, 5000, -8388608, 0, 1, 0, MODE_OFF, 0);
      sample_row(0, 1, 1, 5000, 12000, 5001, 1, 0, MODE_NORMAL, 0);      // measured above
      sample_row(0, 1, 1, 10000, 1000, 0, 1, 999, MODE_NORMAL, 0);       // duty 1, capped
      sample_row(0, 1, 1, 8388607, 12000, 0, 0, 0, MODE_OFF, 0);         // setpoint clamped
      sample_row(0, 1, 1, 4000, 12000, -8388608, 0, 0, MODE_OFF, 0);
      sample_row(0, 1, 1, 500, 12000, 0, 1, 0, MODE_NORMAL, 0);          // low deadband
      sample_row(0, 1, 1, 9600, 10000, 0, 0, 0, MODE_OFF, 0);            // high deadband
      sample_row(0, 1, 1, -8388608, 12000, 0, 0, 0, MODE_OFF, 0);
      // Duty window 0.2 .. 0.8
      csr_row(CSR_MIN_DUTY, 13107);
      csr_row(CSR_MAX_DUTY, 52429);
      sample_row(0, 1, 1, 1000, 12000, 0, 1, 0, MODE_OFF, 0);            // below minimum
      sample_row(0, 1, 1, 10000, 11000, 0, 1, 999, MODE_FULL, 0);        // above maximum
      sample_row(0, 1, 1, 6000, 12000, 0, 0, 0, MODE_OFF, 0);
      sample_row(0, 1, 1, 6000, 12000, 7000, 1, 0, MODE_OFF, 0);
      // Guard resistance, full period, everything open
      csr_row(CSR_MIN_LOAD, 0);
      csr_row(CSR_PERIOD_TOP, 65535);
      csr_row(CSR_MIN_DUTY, 0);
      csr_row(CSR_MAX_DUTY, 65536);
      csr_row(CSR_CURRENT_LIM, 8388607);
      csr_row(CSR_OVER_VOLTAGE, 8388607);
      sample_row(0, 1, 1, 1, 8388606, 0, 1, 65535, MODE_NORMAL, 0);
      sample_row(0, 1, 1, 0, 100, -8388608, 1, 0, MODE_NORMAL, 0);
      sample_row(0, 1, 1, 8388607, 8388606, 8388607, 0, 0, MODE_OFF, 0);
      // Largest load, zero period, then no headroom for any duty
      csr_row(CSR_MIN_LOAD, 16777215);
      csr_row(CSR_PERIOD_TOP, 0);
      sample_row(0, 1, 1, 1, 8388606, 0, 0, 0, MODE_OFF, 0);
      csr_row(CSR_MAX_DUTY, 0);
      sample_row(0, 1, 1, 5000, 5000, 0, 1, 0, MODE_FULL, 0);
      // Write to an unused index changes nothing
      csr_row(CSR_SPARE, 16777215);
      sample_row(0, 1, 1, 5000, 5000, 0, 1, 0, MODE_FULL, 0);

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            if (i == 0 || !script[i-1].is_csr) drain();
            write_csr(script[i].csr_idx, script[i].csr_val);
         end else begin
            send_sample(script[i].smp, script[i].typed, script[i].want);
         end
      end
      n_directed = n_sent;

      // Random phases, each under a fresh register setting
      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         random_config(ph);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            send_sample(make_sample(), 1'b0, none);
            if (!burst) begin
               gap_sel = $urandom_range(0, 99);
               if (gap_sel >= 92) idle_cycles($urandom_range(8, 40));
               else if (gap_sel >= 60) idle_cycles($urandom_range(1, 3));
            end
         end
      end

      // Let the pipeline empty
      idle_cycles(1);
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (PIPE_LAT) @(posedge clock);

      $display("Sent %0d transactions (%0d directed) over %0d register settings; %0d checked.",
               n_sent, n_directed, n_settings, n_checked);
      $display("Expected modes: off %0d, full %0d, normal %0d, no update %0d.",
               mode_hits[MODE_OFF], mode_hits[MODE_FULL], mode_hits[MODE_NORMAL],
               mode_hits[MODE_HOLD]);
      if (n_fail == 0 && pending_drive.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
